[rtl/core/ctc_pkg.sv]
// Package for the capacitated tree checker.
// Holds the sizes, register indexes and the structs shared by the core modules.
// Depends on nothing.
package ctc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VERTEX_W     = 8;
  localparam int DEMAND_W     = 24;
  localparam int COST_W       = 24;
  localparam int DATA_W       = 32;
  localparam int CHILD_W      = 8;
  localparam int CFG_IDX_W    = 1;
  // common width for comparing vertex indexes against counts
  localparam int CMP_W        = ((VERTEX_W > CNT_W) ? VERTEX_W : CNT_W) + 1;

  localparam logic [CHILD_W-1:0]   CHILD_MAX    = '1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROOT     = CFG_IDX_W'(1);

  // vertex store write port, driven by the loader
  typedef struct packed {
    logic                we;
    logic [VIDX_W-1:0]   addr;
    logic [VERTEX_W-1:0] parent;
    logic [DEMAND_W-1:0] demand;
  } load_t;

  // kick-off of a check after the last vertex
  typedef struct packed {
    logic                start;
    logic [CNT_W-1:0]    n;
    logic [VERTEX_W-1:0] root;
    logic                too_many;
  } start_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic bad;
    logic over;
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              over;
  } alu_rsp_t;

  function automatic logic [VIDX_W-1:0] to_vidx(input logic [VERTEX_W-1:0] x);
    return VIDX_W'(x);
  endfunction

endpackage

[rtl/core/ctc_alu.sv]
// Shared saturating adder with limit compare.
// Serves the cost accumulation while loading and the subtree sums while checking.
// Depends on ctc_pkg.
module ctc_alu import ctc_pkg::*; (
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] limit,
  output alu_rsp_t          rsp
);

  logic [DATA_W:0] raw;

  assign raw      = {1'b0, req.a} + {1'b0, req.b};
  // clamp on carry out
  assign rsp.sum  = raw[DATA_W] ? '1 : raw[DATA_W-1:0];
  assign rsp.over = rsp.sum > limit;

endmodule

[rtl/core/ctc_engine.sv]
// Check sequencer: vertex stores, subtree demand store and the parent walk.
// Uses the shared adder through alu_req/alu_rsp.
// Depends on ctc_pkg.
module ctc_engine import ctc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  load_t    load,
  input  start_t   start,
  input  logic     ack,
  output alu_req_t alu_req,
  input  alu_rsp_t alu_rsp,
  output status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_STEP,
    S_ACC,
    S_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    v;
  logic [CNT_W-1:0]    steps;
  logic [VERTEX_W-1:0] root;
  logic [VIDX_W-1:0]   s;
  logic [VIDX_W-1:0]   head;
  logic                bad;
  logic                over;

  logic [VERTEX_W-1:0] parent_mem [MAX_VERTICES];
  logic [DEMAND_W-1:0] demand_mem [MAX_VERTICES];
  logic [DATA_W-1:0]   sub_mem    [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] sub_vld;

  logic [VERTEX_W-1:0] p_rd;
  logic [DEMAND_W-1:0] d_rd;
  logic [DATA_W-1:0]   sub_rd;
  logic                sub_vld_rd;

  logic              start_bad;
  logic              next_done;
  logic              v_is_root;
  logic              p_out;
  logic              p_hit;
  logic              step_over;
  logic              p_rd_en;
  logic [VIDX_W-1:0] p_rd_addr;
  logic              d_rd_en;
  logic              sub_rd_en;
  logic              sub_we;

  assign start_bad = start.too_many || (CMP_W'(start.root) >= CMP_W'(start.n));
  assign next_done = (v == n);
  assign v_is_root = (CMP_W'(v) == CMP_W'(root));
  assign p_out     = (CMP_W'(p_rd) >= CMP_W'(n));
  assign p_hit     = (p_rd == root);
  assign step_over = (CMP_W'(steps) + CMP_W'(1)) > CMP_W'(n);

  assign d_rd_en   = (state == S_NEXT) && !next_done && !v_is_root;
  assign p_rd_en   = d_rd_en ||
                     ((state == S_STEP) && !p_out && !p_hit && !step_over);
  assign p_rd_addr = (state == S_NEXT) ? v[VIDX_W-1:0] : to_vidx(p_rd);
  assign sub_rd_en = (state == S_STEP) && !p_out && p_hit;
  assign sub_we    = (state == S_ACC);

  // entries never written this tree read as zero
  assign alu_req.a = sub_vld_rd ? sub_rd : '0;
  assign alu_req.b = DATA_W'(d_rd);

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE);
  assign status.bad  = bad;
  assign status.over = over;

  always_ff @(posedge clk) begin
    if (load.we) begin
      parent_mem[load.addr] <= load.parent;
    end
    if (p_rd_en) begin
      p_rd <= parent_mem[p_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load.we) begin
      demand_mem[load.addr] <= load.demand;
    end
    if (d_rd_en) begin
      d_rd <= demand_mem[v[VIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (sub_we) begin
      sub_mem[head] <= alu_rsp.sum;
    end
    if (sub_rd_en) begin
      sub_rd <= sub_mem[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_vld <= '0;
    end else if ((state == S_DONE) && ack) begin
      sub_vld <= '0;
    end else if (sub_we) begin
      sub_vld[head] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sub_rd_en) begin
      sub_vld_rd <= sub_vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bad   <= 1'b0;
      over  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start.start) begin
            n     <= start.n;
            root  <= start.root;
            v     <= '0;
            over  <= 1'b0;
            bad   <= start_bad;
            state <= start_bad ? S_DONE : S_NEXT;
          end
        end
        S_NEXT: begin
          if (next_done) begin
            state <= S_DONE;
          end else if (v_is_root) begin
            v <= v + 1'b1;
          end else begin
            s     <= v[VIDX_W-1:0];
            steps <= '0;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (p_out) begin
            bad   <= 1'b1;
            state <= S_DONE;
          end else if (p_hit) begin
            head  <= s;
            state <= S_ACC;
          end else if (step_over) begin
            bad   <= 1'b1;
            state <= S_DONE;
          end else begin
            s     <= to_vidx(p_rd);
            steps <= steps + 1'b1;
          end
        end
        S_ACC: begin
          over  <= over | alu_rsp.over;
          v     <= v + 1'b1;
          state <= S_NEXT;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/capacitated_tree_checker.sv]
// Top level of the capacitated tree checker: loader, configuration and result register.
// Depends on ctc_pkg, ctc_alu and ctc_engine.
//
// Usage
//   Write capacity (index REG_CAPACITY) and root_vertex (index REG_ROOT) through
//   cfg_we/cfg_index/cfg_data while the block is idle. Then send one input
//   transaction per vertex in vertex order 0, 1, 2, ...; the transaction with
//   last_vertex set closes the tree.
//   Input: a transaction completes on a rising edge with in_valid high and in_stall
//   low. Vertices load at one per cycle while the sequencer is idle.
//   Check: after the last vertex in_stall stays high while the sequencer walks parent
//   links. For each non-root vertex it reads the parent store once per link up to
//   the root's child, then reads that child's subtree sum and adds the vertex demand
//   with the saturating adder; the root is skipped, and the check ends with the
//   hand-over of the verdict. A bad root or an overflowed load ends at once.
//   Output: one result transaction per tree, held in an output register. While the
//   receiver stalls, the result holds and the next tree may already load; a second
//   verdict waits until the register is free.
//   Reset clears the registers, the counters and the subtree valid bits; the vertex
//   stores need no clearing, as every entry read is written earlier in that tree.
module capacitated_tree_checker import ctc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VERTEX_W-1:0]  parent_index,
  input  logic [DEMAND_W-1:0]  node_demand,
  input  logic [COST_W-1:0]    edge_cost,
  input  logic                 last_vertex,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    total_cost,
  output logic [CHILD_W-1:0]   subtree_count,
  output logic                 feasible,
  output logic                 malformed
);

  // configuration
  logic [DATA_W-1:0]   capacity;
  logic [VERTEX_W-1:0] root_vertex;

  // per-tree load state
  logic [CNT_W-1:0]    vertex_count;
  logic [CNT_W-1:0]    vertex_count_next;
  logic [DATA_W-1:0]   cost_sum;
  logic [DATA_W-1:0]   cost_sum_next;
  logic [CHILD_W-1:0]  child_count;
  logic [CHILD_W-1:0]  child_count_next;
  logic                too_many;
  logic                too_many_next;

  // totals of the tree under check, waiting for the verdict
  logic [DATA_W-1:0]   res_cost;
  logic [CHILD_W-1:0]  res_child;

  logic     accept;
  logic     room;
  logic     counted;
  logic     ack;
  load_t    load;
  start_t   start;
  status_t  eng_status;
  alu_req_t eng_req;
  alu_req_t load_req;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Configuration writes: plain registers, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= '0;
      root_vertex <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity    <= cfg_data;
        REG_ROOT:     root_vertex <= cfg_data[VERTEX_W-1:0];
      endcase
    end
  end

  // Hold input while a check runs or its verdict waits for the output register.
  assign in_stall = eng_status.busy;
  assign accept   = in_valid && !in_stall;

  // Drop vertices beyond the store; the tree is then reported malformed.
  assign room    = vertex_count < CNT_W'(MAX_VERTICES);
  // Skip the root's own cost and parent, using root_vertex as it stands now.
  assign counted = room && (CMP_W'(vertex_count) != CMP_W'(root_vertex));

  assign load_req.a = cost_sum;
  assign load_req.b = DATA_W'(edge_cost);
  // The adder is free for the loader whenever the sequencer is idle.
  assign alu_req    = eng_status.busy ? eng_req : load_req;

  assign cost_sum_next     = counted ? alu_rsp.sum : cost_sum;
  assign child_count_next  = (counted && (parent_index == root_vertex) &&
                              (child_count != CHILD_MAX)) ? child_count + 1'b1 : child_count;
  assign vertex_count_next = room ? vertex_count + 1'b1 : vertex_count;
  assign too_many_next     = too_many || !room;

  assign load.we     = accept && room;
  assign load.addr   = vertex_count[VIDX_W-1:0];
  assign load.parent = parent_index;
  assign load.demand = node_demand;

  // The walk takes the root as it is at the last vertex.
  assign start.start    = accept && last_vertex;
  assign start.n        = vertex_count_next;
  assign start.root     = root_vertex;
  assign start.too_many = too_many_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      cost_sum     <= '0;
      child_count  <= '0;
      too_many     <= 1'b0;
    end else if (accept) begin
      if (last_vertex) begin
        // Park the totals and clear for the next tree.
        res_cost     <= cost_sum_next;
        res_child    <= child_count_next;
        vertex_count <= '0;
        cost_sum     <= '0;
        child_count  <= '0;
        too_many     <= 1'b0;
      end else begin
        vertex_count <= vertex_count_next;
        cost_sum     <= cost_sum_next;
        child_count  <= child_count_next;
        too_many     <= too_many_next;
      end
    end
  end

  ctc_alu u_alu (
    .req   (alu_req),
    .limit (capacity),
    .rsp   (alu_rsp)
  );

  ctc_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .start   (start),
    .ack     (ack),
    .alu_req (eng_req),
    .alu_rsp (alu_rsp),
    .status  (eng_status)
  );

  // Move the verdict across once the output register is empty or being drained.
  assign ack = eng_status.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid     <= 1'b1;
      total_cost    <= res_cost;
      subtree_count <= res_child;
      feasible      <= !eng_status.bad && !eng_status.over;
      malformed     <= eng_status.bad;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && last_vertex) |=> in_stall)
    else $error("input not held after the closing vertex");

  a_ack_fills: assert property (@(posedge clk) disable iff (rst)
    ack |=> out_valid)
    else $error("verdict handed over but no result presented");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(feasible && malformed))
    else $error("result both feasible and malformed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

endmodule
